// ===== src/tlvpl_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvpl_pkg
// Shared types, constants and helper functions of the TLV path lookup parser.
// ----------------------------------------------------------------------------
package tlvpl_pkg;

  localparam int MAX_LEVELS_DEF   = 3;
  localparam int BUFFER_BYTES_DEF = 65536;

  localparam int CFG_AW = 4;   // three 32-bit registers at byte addresses 0, 4, 8
  localparam int CFG_DW = 32;

  localparam logic [15:0] NONE_ID = 16'hFFFF;
  localparam logic [23:0] MAX24   = 24'hFFFFFF;

  typedef enum logic [1:0] {
    REG_PATH_ID0 = 2'd0,
    REG_PATH_ID1 = 2'd1,
    REG_PATH_ID2 = 2'd2
  } tlvpl_reg_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_TRUNC     = 2'd2
  } tlvpl_status_t;

  typedef struct packed {
    logic [15:0] path_id0;
    logic [15:0] path_id1;
    logic [15:0] path_id2;
  } tlvpl_cfg_t;

  typedef struct packed {
    logic               int_ok;
    logic signed [63:0] int_value;
    logic [23:0]        value_len;
    logic [23:0]        value_offset;
    tlvpl_status_t      status;
  } tlvpl_res_t;

  // Clamp a widened offset or record end to 24 bits.
  function automatic logic [23:0] sat24(input logic [25:0] v);
    sat24 = (v > {2'b00, MAX24}) ? MAX24 : v[23:0];
  endfunction

  // Big-endian value sign-extended from 1, 2, 4 or 8 bytes; {ok, value}.
  function automatic logic [64:0] sext_value(input logic [23:0] len,
                                             input logic [63:0] v);
    logic [64:0] r;
    r = '0;
    case (len)
      24'd1:   r = {1'b1, {56{v[7]}}, v[7:0]};
      24'd2:   r = {1'b1, {48{v[15]}}, v[15:0]};
      24'd4:   r = {1'b1, {32{v[31]}}, v[31:0]};
      24'd8:   r = {1'b1, v};
      default: r = '0;
    endcase
    sext_value = r;
  endfunction

endpackage

// ===== src/tlvpl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tlvpl_cfg_regs
// APB-style register file holding the three path ids.
// ----------------------------------------------------------------------------
module tlvpl_cfg_regs
  import tlvpl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output tlvpl_cfg_t        cfg
);

  tlvpl_cfg_t cfg_r;
  logic       wr_en;
  tlvpl_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = tlvpl_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.path_id0 <= 16'h0000;
      cfg_r.path_id1 <= NONE_ID;
      cfg_r.path_id2 <= NONE_ID;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PATH_ID0: cfg_r.path_id0 <= pwdata[15:0];
        REG_PATH_ID1: cfg_r.path_id1 <= pwdata[15:0];
        REG_PATH_ID2: cfg_r.path_id2 <= pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PATH_ID0: prdata = {16'h0000, cfg_r.path_id0};
      REG_PATH_ID1: prdata = {16'h0000, cfg_r.path_id1};
      REG_PATH_ID2: prdata = {16'h0000, cfg_r.path_id2};
      default:      prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== src/tlvpl_core.sv =====
// ----------------------------------------------------------------------------
// tlvpl_core
// Per-byte TLV header decoder and path matcher with its result register.
// ----------------------------------------------------------------------------
module tlvpl_core
  import tlvpl_pkg::*;
#(
  parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tlvpl_cfg_t cfg,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output tlvpl_res_t out_res
);

  // record ends are kept for every level that can be descended from
  localparam int          PE       = (MAX_LEVELS > 1) ? MAX_LEVELS - 1 : 1;
  localparam int          IW       = (PE > 1) ? $clog2(PE) : 1;
  localparam logic [1:0]  LVL_CAP  = 2'(MAX_LEVELS - 1);
  localparam logic [23:0] POS_LAST = 24'(BUFFER_BYTES - 1);

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_ID_HI = 3'd1,
    PH_ID_LO = 3'd2,
    PH_LEN   = 3'd3,
    PH_SKIP  = 3'd4,
    PH_VALUE = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  level_r, level_nxt;
  logic [23:0] pend_r   [PE];
  logic [23:0] pend_nxt [PE];
  logic [23:0] pos_r, pos_nxt;
  logic [7:0]  htype_r, htype_nxt;
  logic [15:0] id_r, id_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] left_r, left_nxt;
  logic [63:0] val_r, val_nxt;
  logic        done_r, done_nxt;

  logic        out_valid_r;
  tlvpl_res_t  res_r, res_nxt;

  logic        accept, last_eff, emit;
  logic        hdr_end, to_type, found;
  logic [24:0] next_pos;
  logic [1:0]  final_lvl;
  logic [15:0] sid;
  logic [1:0]  lvl_up;
  logic [23:0] trunc_done;
  logic [64:0] sx;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign last_eff = in_last || (pos_r >= POS_LAST);
  assign next_pos = {1'b0, pos_r} + 25'd1;

  always_comb begin
    if (cfg.path_id1 == NONE_ID)      final_lvl = 2'd0;
    else if (cfg.path_id2 == NONE_ID) final_lvl = 2'd1;
    else                              final_lvl = 2'd2;
    if (final_lvl > LVL_CAP) final_lvl = LVL_CAP;
  end

  always_comb begin
    case (level_r)
      2'd0:    sid = cfg.path_id0;
      2'd1:    sid = cfg.path_id1;
      default: sid = cfg.path_id2;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    pend_nxt   = pend_r;
    pos_nxt    = pos_r;
    htype_nxt  = htype_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    left_nxt   = left_r;
    val_nxt    = val_r;
    done_nxt   = done_r;
    hdr_end    = 1'b0;
    to_type    = 1'b0;
    found      = 1'b0;
    emit       = 1'b0;
    lvl_up     = 2'd0;
    trunc_done = 24'd0;
    sx         = '0;
    res_nxt    = '0;
    res_nxt.status = ST_NOT_FOUND;

    if (!done_r) begin
      case (phase_r)
        PH_TYPE: begin
          htype_nxt = in_byte;
          id_nxt    = 16'h0000;
          len_nxt   = 24'd0;
          phase_nxt = in_byte[5] ? PH_ID_HI : PH_ID_LO;
        end
        PH_ID_HI: begin
          id_nxt    = {8'h00, in_byte};
          phase_nxt = PH_ID_LO;
        end
        PH_ID_LO: begin
          id_nxt = {id_r[7:0], in_byte};
          if (htype_r[4:3] == 2'd0) begin
            len_nxt = {21'd0, htype_r[2:0]};
            hdr_end = 1'b1;
          end else begin
            phase_nxt = PH_LEN;
            left_nxt  = {22'd0, htype_r[4:3]};
          end
        end
        PH_LEN: begin
          len_nxt  = {len_r[15:0], in_byte};
          left_nxt = left_r - 24'd1;
          hdr_end  = (left_r == 24'd1);
        end
        PH_SKIP: begin
          left_nxt = left_r - 24'd1;
          to_type  = (left_r == 24'd1);
        end
        PH_VALUE: begin
          val_nxt  = {val_r[55:0], in_byte};
          left_nxt = left_r - 24'd1;
          found    = (left_r == 24'd1);
        end
        default: phase_nxt = PH_TYPE;
      endcase

      // header complete: match, descend or skip
      if (hdr_end) begin
        if (id_nxt == sid) begin
          if (level_r >= final_lvl) begin
            if (len_nxt == 24'd0) begin
              found = 1'b1;
            end else begin
              phase_nxt = PH_VALUE;
              left_nxt  = len_nxt;
              val_nxt   = 64'd0;
            end
          end else begin
            pend_nxt[level_r[IW-1:0]] = sat24({1'b0, next_pos} + {2'b00, len_nxt});
            level_nxt = level_r + 2'd1;
            to_type   = 1'b1;
          end
        end else if (len_nxt == 24'd0) begin
          to_type = 1'b1;
        end else begin
          phase_nxt = PH_SKIP;
          left_nxt  = len_nxt;
        end
      end

      // next record position; nested search ends at the parent's extent
      if (to_type) begin
        phase_nxt = PH_TYPE;
        lvl_up    = level_nxt - 2'd1;
        if (level_nxt != 2'd0 && next_pos >= {1'b0, pend_nxt[lvl_up[IW-1:0]]}) begin
          emit = 1'b1;
        end
      end

      if (found) begin
        emit                 = 1'b1;
        sx                   = sext_value(len_nxt, val_nxt);
        res_nxt.status       = ST_FOUND;
        res_nxt.value_offset = sat24({1'b0, next_pos - {1'b0, len_nxt}});
        res_nxt.value_len    = len_nxt;
        res_nxt.int_value    = sx[63:0];
        res_nxt.int_ok       = sx[64];
      end

      // buffer ends with nothing reported yet
      if (!emit && last_eff) begin
        emit = 1'b1;
        if (phase_nxt == PH_VALUE) begin
          trunc_done           = len_nxt - left_nxt;
          res_nxt.status       = ST_TRUNC;
          res_nxt.value_offset = sat24({1'b0, next_pos - {1'b0, trunc_done}});
          res_nxt.value_len    = len_nxt;
        end
      end

      if (emit) done_nxt = 1'b1;
    end

    if (last_eff) begin
      phase_nxt = PH_TYPE;
      level_nxt = 2'd0;
      for (int i = 0; i < PE; i++) pend_nxt[i] = 24'd0;
      pos_nxt   = 24'd0;
      htype_nxt = 8'h00;
      id_nxt    = 16'h0000;
      len_nxt   = 24'd0;
      left_nxt  = 24'd0;
      val_nxt   = 64'd0;
      done_nxt  = 1'b0;
    end else begin
      pos_nxt = next_pos[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      level_r     <= 2'd0;
      for (int i = 0; i < PE; i++) pend_r[i] <= 24'd0;
      pos_r       <= 24'd0;
      htype_r     <= 8'h00;
      id_r        <= 16'h0000;
      len_r       <= 24'd0;
      left_r      <= 24'd0;
      val_r       <= 64'd0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        level_r <= level_nxt;
        pend_r  <= pend_nxt;
        pos_r   <= pos_nxt;
        htype_r <= htype_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        left_r  <= left_nxt;
        val_r   <= val_nxt;
        done_r  <= done_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // a result always lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> out_valid_r)
    else $error("result lost");

  // the final byte returns the parser to its start state
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_eff) |=> (phase_r == PH_TYPE && level_r == 2'd0 &&
                              pos_r == 24'd0 && !done_r))
    else $error("buffer end did not clear state");

  // a counted phase never sits at zero while still searching
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (!done_r && (phase_r == PH_VALUE || phase_r == PH_SKIP || phase_r == PH_LEN))
      |-> (left_r != 24'd0))
    else $error("byte counter exhausted");

  // descent never exceeds the configured depth
  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_CAP)
    else $error("level beyond cap");

endmodule

// ===== src/tlv_path_lookup_parser_top.sv =====
// ----------------------------------------------------------------------------
// tlv_path_lookup_parser_top
// LwM2M TLV path lookup: streams buffer bytes, reports the addressed value.
// ----------------------------------------------------------------------------
// The block takes one TLV buffer byte per cycle on the input stream (tlast on
// the final byte) and follows the path set in path_id0..2 through nested
// records, giving at most one result per buffer: found (offset, length and,
// for 1/2/4/8-byte values, the sign-extended integer), not found, or
// truncated. Every byte is one transfer; the result is presented the cycle
// after the byte that decides it and sits in a single output register, so the
// input stalls only while that register holds an untaken result. Bytes after
// a result are consumed and ignored until the buffer ends. The user must write
// path registers over the APB port between buffers, unenforced by the block.
// ----------------------------------------------------------------------------
module tlv_path_lookup_parser_top
  import tlvpl_pkg::*;
#(
  parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream: one buffer byte per transfer
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] data_byte
  input  logic              in_tlast,    // last_byte
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [111:0]      out_tdata,   // [23:0] value_offset, [47:24] value_len,
                                         // [111:48] int_value
  output logic [2:0]        out_tuser,   // [1:0] status, [2] int_ok
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  tlvpl_cfg_t cfg;
  tlvpl_res_t res;

  tlvpl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tlvpl_core #(
    .MAX_LEVELS   (MAX_LEVELS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // pack the result, first field lowest
  assign out_tdata = {res.int_value, res.value_len, res.value_offset};
  assign out_tuser = {res.int_ok, res.status};

endmodule
